FILE: hdl/hlfd_pkg.sv
// Shared types and constants for the header/length frame deframer.
`timescale 1ns / 1ps

package hlfd_pkg;

  localparam int LenFieldBytes = 8;
  localparam int LengthBits    = 32;

  localparam logic [7:0] SyncFirst  = 8'h48;  // 'H'
  localparam logic [7:0] SyncSecond = 8'h54;  // 'T'

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } result_t;

endpackage

FILE: hdl/hlfd_in_reg.sv
// Input register stage: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module hlfd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  assign s_ready_o = !valid_q || ready_i;
  assign valid_d   = (s_valid_i && s_ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/hlfd_core.sv
// Sync hunt, length assembly and payload countdown for one byte per cycle while the result register has room.
`timescale 1ns / 1ps

module hlfd_core #(
  parameter int LEN_FIELD_BYTES = hlfd_pkg::LenFieldBytes,
  parameter int LENGTH_BITS     = hlfd_pkg::LengthBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output hlfd_pkg::result_t   res_o
);

  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhSync2 = 2'd1;
  localparam logic [1:0] PhLen  = 2'd2;
  localparam logic [1:0] PhData = 2'd3;

  localparam logic [2:0] LastIdx = 3'(LEN_FIELD_BYTES - 1);

  logic [1:0]             phase_q, phase_d;
  logic [2:0]             hdr_cnt_q, hdr_cnt_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic                   first_q, first_d;
  logic [LENGTH_BITS-1:0] len_next;
  logic                   take;

  // the result register can always hold one beat, so take only when it has room
  assign in_ready_o = res_ready_i;
  assign take       = in_valid_i && res_ready_i;

  assign len_next = LENGTH_BITS'(({8'd0, len_q}) |
                    ({{LENGTH_BITS{1'b0}}, in_byte_i} << {hdr_cnt_q, 3'b000}));

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_d       = len_q;
    remain_d    = remain_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o.data  = in_byte_i;
    res_o.last  = (remain_q == LENGTH_BITS'(1));
    res_o.first = first_q;
    if (take) begin
      case (phase_q)
        PhHunt: begin
          if (in_byte_i == hlfd_pkg::SyncFirst) phase_d = PhSync2;
        end
        PhSync2: begin
          if (in_byte_i == hlfd_pkg::SyncSecond) begin
            phase_d   = PhLen;
            hdr_cnt_d = 3'd0;
            len_d     = '0;
          end else if (in_byte_i != hlfd_pkg::SyncFirst) begin
            phase_d = PhHunt;
          end
        end
        PhLen: begin
          len_d = len_next;
          if (hdr_cnt_q >= LastIdx) begin
            hdr_cnt_d = 3'd0;
            if (len_next == '0) begin
              phase_d = PhHunt;
            end else begin
              remain_d = len_next;
              first_d  = 1'b1;
              phase_d  = PhData;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        default: begin
          if (remain_q == '0) begin
            phase_d = PhHunt;
          end else begin
            res_valid_o = 1'b1;
            first_d     = 1'b0;
            remain_d    = remain_q - LENGTH_BITS'(1);
            if (remain_q == LENGTH_BITS'(1)) phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      hdr_cnt_q <= 3'd0;
      len_q     <= '0;
      remain_q  <= '0;
      first_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      remain_q  <= remain_d;
      first_q   <= first_d;
    end
  end

`ifndef SYNTHESIS
  a_len_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLen) |-> (hdr_cnt_q <= LastIdx))
    else $error("length byte count past field size");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (remain_q != '0))
    else $error("payload phase with nothing left");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> (phase_q == PhHunt))
    else $error("last beat did not return to hunt");

  a_first_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.first) |=> !first_q)
    else $error("first flag not cleared after first beat");
`endif

endmodule

FILE: hdl/hlfd_out_reg.sv
// Output register: holds one result beat while the receiver stalls.
`timescale 1ns / 1ps

module hlfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  hlfd_pkg::result_t res_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output hlfd_pkg::result_t m_res_o
);

  logic              valid_q, valid_d;
  hlfd_pkg::result_t res_q;

  assign res_ready_o = !valid_q || m_ready_i;
  assign valid_d     = (res_valid_i && res_ready_o) || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

FILE: hdl/header_length_frame_deframer_top.sv
// Top level of the header/length frame deframer.
//
// Slave side carries the raw byte stream, one byte per beat. The block hunts
// for the sync pair 'H','T', reads a little-endian length field of
// LEN_FIELD_BYTES bytes (only the low LENGTH_BITS bits count), then passes that
// many following bytes out on the master side. tuser marks the first payload
// beat of a frame, tlast the final one; a one-byte frame has both set.
// Sync, length and stray bytes give no output beat; a zero length gives none.
// A payload byte passes from the input register through the combinational
// parser into the result register before it reaches the master side.
// Throughput: one byte per cycle while the master side accepts every beat.
// When the master side stalls, the result register holds its beat, the input
// register holds one more, and s_axis_tready_o drops after that.
// Reset empties both registers and returns the parser to the sync hunt.
`timescale 1ns / 1ps

module header_length_frame_deframer_top #(
  parameter int LEN_FIELD_BYTES = hlfd_pkg::LenFieldBytes,
  parameter int LENGTH_BITS     = hlfd_pkg::LengthBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] payload_byte
  output logic       m_axis_tlast_o,   // payload_last
  output logic       m_axis_tuser_o    // [0] payload_first
);

  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_byte;
  logic              res_valid;
  logic              res_ready;
  hlfd_pkg::result_t res;
  hlfd_pkg::result_t m_res;

  hlfd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .valid_o   (in_valid),
    .ready_i   (in_ready),
    .data_o    (in_byte)
  );

  hlfd_core #(
    .LEN_FIELD_BYTES (LEN_FIELD_BYTES),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  hlfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata_o = m_res.data;
  assign m_axis_tlast_o = m_res.last;
  assign m_axis_tuser_o = m_res.first;

endmodule
